// File: rtl/ackermann_steering_kinematics_top_macros.svh
// Assertion macros shared by the checker of the steering kinematics block.
// Depends on nothing; include by bare file name.
`ifndef ACKERMANN_STEERING_KINEMATICS_TOP_MACROS_SVH
`define ACKERMANN_STEERING_KINEMATICS_TOP_MACROS_SVH

// check a property while out of reset
`define AKS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check a property at every edge, reset included
`define AKS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/aks_pkg.sv
// Shared types, constants and tables of the steering kinematics block.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package aks_pkg;

    localparam int NCELLS = 24;

    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_TRACK  = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    localparam logic [15:0] RST_BASE   = 16'd1229;
    localparam logic [15:0] RST_TRACK  = 16'd819;
    localparam logic [15:0] RST_RADIUS = 16'd205;

    localparam logic signed [17:0] HALF_PI_Q14 = 18'sd25736;
    localparam logic [23:0] RATE_MAX_MAG = 24'd8388607;
    localparam logic [23:0] RATE_MIN_MAG = 24'd8388608;

    typedef struct packed {
        logic [15:0] base_q12;
        logic [15:0] track_q12;
        logic [15:0] radius_q12;
    } t_geom;

    typedef struct packed {
        logic signed [43:0] x;
        logic signed [43:0] y;
        logic signed [33:0] z;
        logic [35:0]        rem;
        logic [23:0]        q;
        logic               neg;
        logic               ang_zero;
        logic               ang_half;
        logic               dzero;
        logic               sat_hi;
    } t_lane;

    typedef t_lane [1:0] t_lanes;

    // arctangent of 2^-i in Q2.30
    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        logic signed [33:0] a;
        case (idx)
            5'd0:    a = 34'sd843314857;
            5'd1:    a = 34'sd497837829;
            5'd2:    a = 34'sd263043837;
            5'd3:    a = 34'sd133525159;
            5'd4:    a = 34'sd67021687;
            5'd5:    a = 34'sd33543516;
            5'd6:    a = 34'sd16775851;
            5'd7:    a = 34'sd8388437;
            5'd8:    a = 34'sd4194283;
            5'd9:    a = 34'sd2097149;
            5'd10:   a = 34'sd1048576;
            5'd11:   a = 34'sd524288;
            5'd12:   a = 34'sd262144;
            5'd13:   a = 34'sd131072;
            5'd14:   a = 34'sd65536;
            5'd15:   a = 34'sd32768;
            5'd16:   a = 34'sd16384;
            5'd17:   a = 34'sd8192;
            5'd18:   a = 34'sd4096;
            5'd19:   a = 34'sd2048;
            5'd20:   a = 34'sd1024;
            5'd21:   a = 34'sd512;
            5'd22:   a = 34'sd256;
            5'd23:   a = 34'sd128;
            default: a = '0;
        endcase
        return a;
    endfunction

    // left shift that brings the larger magnitude up to bit 40
    function automatic logic [5:0] norm_shift(input logic [35:0] v);
        logic [5:0] msb;
        msb = '0;
        for (int k = 0; k < 36; k++) begin
            if (v[k]) msb = 6'(k);
        end
        return 6'd40 - msb;
    endfunction

endpackage

`default_nettype wire

// File: rtl/aks_front.sv
// Front stages: wheel offsets, numerator, sign fold, normalisation and divider setup.
// Depends on aks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aks_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  wire signed [15:0]    i_speed,
    input  wire signed [15:0]    i_yaw,
    input  wire aks_pkg::t_geom  i_geom,
    output logic                 o_valid,
    output aks_pkg::t_lanes      o_lanes
);

    logic [4:0] r_vld;

    // stage A: products
    logic signed [15:0] r_a_v;
    logic signed [32:0] r_a_tw;
    logic signed [32:0] r_a_bw;
    logic               r_a_wz;
    logic signed [32:0] n_a_tw;
    logic signed [32:0] n_a_bw;

    // stage B: offsets
    logic signed [34:0] r_b_d [2];
    logic signed [34:0] r_b_num;
    logic               r_b_wz;
    logic signed [34:0] n_b_vs;

    // stage C: sign fold
    logic [34:0]        r_c_x  [2];
    logic signed [34:0] r_c_y  [2];
    logic [34:0]        r_c_ay [2];
    logic [1:0]         r_c_neg;
    logic [1:0]         r_c_dz;
    logic               r_c_wz;

    // stage D: shift search and rounding offset
    logic [34:0]        r_d_x  [2];
    logic signed [34:0] r_d_y  [2];
    logic [5:0]         r_d_sh [2];
    logic [35:0]        r_d_a  [2];
    logic [1:0]         r_d_neg;
    logic [1:0]         r_d_dz;
    logic               r_d_wz;

    aks_pkg::t_lanes    r_e_lanes;
    aks_pkg::t_lanes    n_e_lanes;

    assign n_a_tw = $signed({1'b0, i_geom.track_q12}) * i_yaw;
    assign n_a_bw = $signed({1'b0, i_geom.base_q12}) * i_yaw;
    assign n_b_vs = $signed({{2{r_a_v[15]}}, r_a_v, 17'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_v   <= i_speed;
            r_a_tw  <= n_a_tw;
            r_a_bw  <= n_a_bw;
            r_a_wz  <= (i_yaw == 16'sd0);

            r_b_d[0] <= n_b_vs - {{2{r_a_tw[32]}}, r_a_tw};
            r_b_d[1] <= n_b_vs + {{2{r_a_tw[32]}}, r_a_tw};
            r_b_num  <= {r_a_bw[32], r_a_bw, 1'b0};
            r_b_wz   <= r_a_wz;

            for (int l = 0; l < 2; l++) begin
                r_c_neg[l] <= r_b_d[l][34];
                r_c_dz[l]  <= (r_b_d[l] == 35'sd0);
                r_c_x[l]   <= r_b_d[l][34] ? 35'(-r_b_d[l]) : 35'(r_b_d[l]);
                r_c_y[l]   <= r_b_d[l][34] ? -r_b_num : r_b_num;
                r_c_ay[l]  <= r_b_num[34] ? 35'(-r_b_num) : 35'(r_b_num);
            end
            r_c_wz <= r_b_wz;

            for (int l = 0; l < 2; l++) begin
                r_d_x[l]  <= r_c_x[l];
                r_d_y[l]  <= r_c_y[l];
                r_d_sh[l] <= aks_pkg::norm_shift({1'b0, r_c_x[l] | r_c_ay[l]});
                r_d_a[l]  <= {1'b0, r_c_x[l]} + {16'b0, i_geom.radius_q12, 4'b0};
            end
            r_d_neg <= r_c_neg;
            r_d_dz  <= r_c_dz;
            r_d_wz  <= r_c_wz;

            r_e_lanes <= n_e_lanes;
        end
    end

    // the magnitude of y is taken from num directly: |y| = |num|
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_e_lanes[l].x        = $signed({9'b0, r_d_x[l]} << r_d_sh[l]);
            n_e_lanes[l].y        = $signed({{9{r_d_y[l][34]}}, r_d_y[l]}) <<< r_d_sh[l];
            n_e_lanes[l].z        = '0;
            n_e_lanes[l].rem      = r_d_a[l];
            n_e_lanes[l].q        = '0;
            n_e_lanes[l].neg      = r_d_neg[l];
            n_e_lanes[l].ang_zero = r_d_wz;
            n_e_lanes[l].ang_half = r_d_dz[l] & ~r_d_wz;
            n_e_lanes[l].dzero    = r_d_dz[l];
            n_e_lanes[l].sat_hi   = {9'b0, r_d_a[l]} >= {i_geom.radius_q12, 29'b0};
        end
    end

    assign o_valid = r_vld[4];
    assign o_lanes = r_e_lanes;

endmodule

`default_nettype wire

// File: rtl/aks_cell.sv
// One cell of the chain: a restoring divider step per lane, plus a CORDIC vectoring step when IDX < ITERS.
// Depends on aks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aks_cell #(
    parameter int IDX   = 0,
    parameter int ITERS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  wire aks_pkg::t_geom  i_geom,
    input  wire aks_pkg::t_lanes i_lanes,
    output logic                 o_valid,
    output aks_pkg::t_lanes      o_lanes
);

    localparam int  QB     = aks_pkg::NCELLS - 1 - IDX;
    localparam bit  ACTIVE = (IDX < ITERS);

    logic               r_vld;
    aks_pkg::t_lanes    r_lanes;
    aks_pkg::t_lanes    n_lanes;
    logic [44:0]        ds;

    assign ds = {24'b0, i_geom.radius_q12, 5'b0} << QB;

    always_comb begin
        n_lanes = i_lanes;
        for (int l = 0; l < 2; l++) begin
            if (ACTIVE) begin
                if (i_lanes[l].y > 44'sd0) begin
                    n_lanes[l].x = i_lanes[l].x + (i_lanes[l].y >>> IDX);
                    n_lanes[l].y = i_lanes[l].y - (i_lanes[l].x >>> IDX);
                    n_lanes[l].z = i_lanes[l].z + aks_pkg::atan_q30(5'(IDX));
                end else begin
                    n_lanes[l].x = i_lanes[l].x - (i_lanes[l].y >>> IDX);
                    n_lanes[l].y = i_lanes[l].y + (i_lanes[l].x >>> IDX);
                    n_lanes[l].z = i_lanes[l].z - aks_pkg::atan_q30(5'(IDX));
                end
            end
            if ({9'b0, i_lanes[l].rem} >= ds) begin
                n_lanes[l].rem   = i_lanes[l].rem - ds[35:0];
                n_lanes[l].q[QB] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lanes <= n_lanes;
        end
    end

    assign o_valid = r_vld;
    assign o_lanes = r_lanes;

endmodule

`default_nettype wire

// File: rtl/ackermann_steering_kinematics_top.sv
// Top level of the steering kinematics block: config registers, front, cell chain, output.
// Depends on aks_pkg, aks_front and aks_cell.
//
//  channel   direction  handshake                  payload
//  s         in         i_s_tvalid / o_s_tready    speed, yaw rate
//  m         out        o_m_tvalid / i_m_tready    angles, wheel rates; tuser saturated
//  cfg       in         i_cfg_valid / o_cfg_ready  register index, data
//
// One word per cycle enters while the pipe advances; it passes four product and fold stages,
// one setup stage, 24 chain cells (divider bit each; CORDIC step in the first ANGLE_ITERATIONS), one output register.
// The whole pipe advances when the output register is empty or taken, else it holds.
// Synchronous active-low reset clears valid bits and loads the default geometry.
`timescale 1ns / 1ps
`default_nettype none

module ackermann_steering_kinematics_top #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,    // [15:0] linear_speed, [31:16] yaw_rate
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [79:0] o_m_tdata,    // [15:0] left_steer_angle, [31:16] right_steer_angle,
                                      // [55:32] left_wheel_rate, [79:56] right_wheel_rate
    output logic [0:0]  o_m_tuser,    // [0] saturated
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int NC = aks_pkg::NCELLS;

    aks_pkg::t_geom     r_geom;
    logic               en;
    logic               r_out_vld;
    logic [79:0]        r_out_data;
    logic               r_out_sat;
    logic [79:0]        n_out_data;
    logic               n_out_sat;

    logic               front_vld;
    aks_pkg::t_lanes    front_lanes;
    logic [NC:0]        chain_vld;
    aks_pkg::t_lanes    chain_lanes [NC+1];

    logic signed [33:0] zs     [2];
    logic signed [17:0] zr     [2];
    logic [1:0]         lsat;

    assign en          = !r_out_vld || i_m_tready;
    assign o_s_tready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.base_q12   <= aks_pkg::RST_BASE;
            r_geom.track_q12  <= aks_pkg::RST_TRACK;
            r_geom.radius_q12 <= aks_pkg::RST_RADIUS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                aks_pkg::CFG_BASE:   r_geom.base_q12   <= i_cfg_data;
                aks_pkg::CFG_TRACK:  r_geom.track_q12  <= i_cfg_data;
                aks_pkg::CFG_RADIUS: r_geom.radius_q12 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aks_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_speed ($signed(i_s_tdata[15:0])),
        .i_yaw   ($signed(i_s_tdata[31:16])),
        .i_geom  (r_geom),
        .o_valid (front_vld),
        .o_lanes (front_lanes)
    );

    assign chain_vld[0]   = front_vld;
    assign chain_lanes[0] = front_lanes;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        aks_cell #(
            .IDX   (g),
            .ITERS (ANGLE_ITERATIONS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (chain_vld[g]),
            .i_geom  (r_geom),
            .i_lanes (chain_lanes[g]),
            .o_valid (chain_vld[g+1]),
            .o_lanes (chain_lanes[g+1])
        );
    end

    // round the angle to Q2.14, clip, apply the zero-yaw and zero-denominator cases;
    // finish the wheel rate with sign and saturation
    always_comb begin
        n_out_data = '0;
        for (int l = 0; l < 2; l++) begin
            zs[l] = chain_lanes[NC][l].z + 34'sd32768;
            zr[l] = zs[l][33:16];
            if (chain_lanes[NC][l].ang_zero) begin
                zr[l] = '0;
            end else if (chain_lanes[NC][l].ang_half || zr[l] > aks_pkg::HALF_PI_Q14) begin
                zr[l] = aks_pkg::HALF_PI_Q14;
            end else if (zr[l] < -aks_pkg::HALF_PI_Q14) begin
                zr[l] = -aks_pkg::HALF_PI_Q14;
            end
            n_out_data[16*l +: 16] = zr[l][15:0];

            lsat[l] = 1'b0;
            if (chain_lanes[NC][l].dzero) begin
                n_out_data[32 + 24*l +: 24] = '0;
            end else if (!chain_lanes[NC][l].neg) begin
                if (chain_lanes[NC][l].sat_hi || chain_lanes[NC][l].q > aks_pkg::RATE_MAX_MAG) begin
                    lsat[l] = 1'b1;
                    n_out_data[32 + 24*l +: 24] = aks_pkg::RATE_MAX_MAG;
                end else begin
                    n_out_data[32 + 24*l +: 24] = chain_lanes[NC][l].q;
                end
            end else begin
                if (chain_lanes[NC][l].sat_hi || chain_lanes[NC][l].q > aks_pkg::RATE_MIN_MAG) begin
                    lsat[l] = 1'b1;
                    n_out_data[32 + 24*l +: 24] = aks_pkg::RATE_MIN_MAG;
                end else begin
                    n_out_data[32 + 24*l +: 24] = 24'(-{1'b0, chain_lanes[NC][l].q});
                end
            end
        end
        n_out_sat = |lsat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= chain_vld[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
            r_out_sat  <= n_out_sat;
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_sat;

endmodule

`default_nettype wire

// File: rtl/aks_checker.sv
// Port-level checks of the steering kinematics block, bound to its top level.
// Depends on ackermann_steering_kinematics_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ackermann_steering_kinematics_top_macros.svh"

module aks_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_s_tready,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [79:0] o_m_tdata
);

    // a stalled word stays on the output
    `AKS_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "output word dropped under stall")

    // reset empties the pipe
    `AKS_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

    // an empty output register never blocks the input
    `AKS_ASSERT(a_ready_free, i_clk, i_rst_n, !o_m_tvalid |-> o_s_tready, "input stalled with empty output")

    // both angles stay within a quarter turn
    `AKS_ASSERT(a_angle_range, i_clk, i_rst_n, o_m_tvalid |-> $signed(o_m_tdata[15:0]) <= 16'sd25736 && $signed(o_m_tdata[15:0]) >= -16'sd25736 && $signed(o_m_tdata[31:16]) <= 16'sd25736 && $signed(o_m_tdata[31:16]) >= -16'sd25736, "steering angle out of range")

endmodule

bind ackermann_steering_kinematics_top aks_checker u_aks_checker (.*);

`default_nettype wire
